// ----- rtl/scmd5_pkg.sv -----
// ----------------------------------------------------------------------------
// scmd5_pkg : shared types and constants of the container checksum
// Round constants, rotate amounts, hash init values and state types.
// ----------------------------------------------------------------------------
package scmd5_pkg;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hefcdab89;
    localparam logic [31:0] H2 = 32'h98badcfe;
    localparam logic [31:0] H3 = 32'h10325476;

    localparam int unsigned HDR_LEN    = 20;
    localparam int unsigned TAIL_LIMIT = 56;

    localparam logic [31:0] MAGIC = 32'h43425844; // "DXBC", little endian

    // top-level sequencer
    typedef enum logic [2:0] {
        ST_TAKE,    // taking bytes
        ST_HASH,    // rounds running on a full payload block
        ST_FIN1,    // rounds on tail block (long tail case)
        ST_FIN2,    // rounds on final count block
        ST_OUT      // emitting result words
    } t_state;

    // control to the round unit
    typedef struct packed {
        logic start;
    } t_rnd_ctl;

    function automatic logic [31:0] sine_k(input logic [5:0] i);
        logic [31:0] t [64];
        t = '{
            32'hd76aa478,32'he8c7b756,32'h242070db,32'hc1bdceee,
            32'hf57c0faf,32'h4787c62a,32'ha8304613,32'hfd469501,
            32'h698098d8,32'h8b44f7af,32'hffff5bb1,32'h895cd7be,
            32'h6b901122,32'hfd987193,32'ha679438e,32'h49b40821,
            32'hf61e2562,32'hc040b340,32'h265e5a51,32'he9b6c7aa,
            32'hd62f105d,32'h02441453,32'hd8a1e681,32'he7d3fbc8,
            32'h21e1cde6,32'hc33707d6,32'hf4d50d87,32'h455a14ed,
            32'ha9e3e905,32'hfcefa3f8,32'h676f02d9,32'h8d2a4c8a,
            32'hfffa3942,32'h8771f681,32'h6d9d6122,32'hfde5380c,
            32'ha4beea44,32'h4bdecfa9,32'hf6bb4b60,32'hbebfbc70,
            32'h289b7ec6,32'heaa127fa,32'hd4ef3085,32'h04881d05,
            32'hd9d4d039,32'he6db99e5,32'h1fa27cf8,32'hc4ac5665,
            32'hf4292244,32'h432aff97,32'hab9423a7,32'hfc93a039,
            32'h655b59c3,32'h8f0ccc92,32'hffeff47d,32'h85845dd1,
            32'h6fa87e4f,32'hfe2ce6e0,32'ha3014314,32'h4e0811a1,
            32'hf7537e82,32'hbd3af235,32'h2ad7d2bb,32'heb86d391};
        return t[i];
    endfunction

    function automatic logic [4:0] rot_amt(input logic [5:0] i);
        logic [4:0] t [16];
        t = '{5'd7,5'd12,5'd17,5'd22, 5'd5,5'd9,5'd14,5'd20,
              5'd4,5'd11,5'd16,5'd23, 5'd6,5'd10,5'd15,5'd21};
        return t[{i[5:4], i[1:0]}];
    endfunction

endpackage

// ----- rtl/scmd5_round.sv -----
// ----------------------------------------------------------------------------
// scmd5_round : shared MD5 round unit
// One round per cycle; message words come from the caller
// by index. Adds the result into the hash state at the end.
// ----------------------------------------------------------------------------
module scmd5_round (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  scmd5_pkg::t_rnd_ctl  i_ctl,
    input  logic                 i_init,      // load hash init values
    input  logic [31:0]          i_msg_word,  // word at o_msg_idx
    output logic [3:0]           o_msg_idx,
    output logic                 o_busy,
    output logic                 o_done,
    output logic [31:0]          o_hash [4]
);

    logic [31:0] r_h [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [5:0]  r_idx;
    logic        r_busy;
    logic        r_done;

    logic [31:0] f, sum, rot;
    logic [3:0]  g;
    logic [4:0]  s;

    // round function and word index
    always_comb begin
        unique case (r_idx[5:4])
            2'd0: begin f = (r_b & r_c) | (~r_b & r_d); g = r_idx[3:0]; end
            2'd1: begin
                f = (r_d & r_b) | (~r_d & r_c);
                g = 4'(5 * r_idx + 1);
            end
            2'd2: begin f = r_b ^ r_c ^ r_d; g = 4'(3 * r_idx + 5); end
            default: begin f = r_c ^ (r_b | ~r_d); g = 4'(7 * r_idx); end
        endcase
        s   = scmd5_pkg::rot_amt(r_idx);
        sum = r_a + f + scmd5_pkg::sine_k(r_idx) + i_msg_word;
        rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
    end

    assign o_msg_idx = g;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
            r_h    <= '{scmd5_pkg::H0, scmd5_pkg::H1, scmd5_pkg::H2, scmd5_pkg::H3};
        end else begin
            r_done <= 1'b0;
            if (i_init) begin
                r_h <= '{scmd5_pkg::H0, scmd5_pkg::H1, scmd5_pkg::H2, scmd5_pkg::H3};
            end else if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3];
            end else if (r_busy) begin
                r_a <= r_d;
                r_d <= r_c;
                r_c <= r_b;
                r_b <= r_b + rot;
                r_idx <= r_idx + 6'd1;
                if (r_idx == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_h[0] <= r_h[0] + r_d;
                    r_h[1] <= r_h[1] + r_b + rot;
                    r_h[2] <= r_h[2] + r_b;
                    r_h[3] <= r_h[3] + r_c;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_hash = r_h;

`ifndef ASSERT_OFF
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_ctl.start) else $error("round start while busy");
    a_done_after_63: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_idx) == 6'd63) else $error("done out of step");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while busy");
`endif

endmodule

// ----- rtl/shader_container_md5_checksum.sv -----
// ----------------------------------------------------------------------------
// shader_container_md5_checksum : modified MD5 checksum of a shader container
// Each full 64-byte payload block holds off input while the shared round
// unit runs on it, so no byte is taken until that block is through.
// Last byte: one or two final blocks, then four words out; a rejected
// container skips the final blocks and gives a single status word.
// Reset: synchronous, active low; returns to the start of a container.
// ----------------------------------------------------------------------------
module shader_container_md5_checksum (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_status,
    output logic [1:0]  o_word_index,
    output logic [31:0] o_checksum_word,
    output logic        o_last_of_run
);

    scmd5_pkg::t_state r_state, n_state;

    // payload block held as 16 little-endian words, one byte lane per write
    logic [31:0] r_store [16];
    logic [31:0] r_total;
    logic        r_magic_ok;
    logic        r_past_hdr;
    logic        r_reject;
    logic        r_long;
    logic [1:0]  r_widx;
    logic [31:0] r_pay;

    // r_reject in ST_HASH marks "last byte closed a full block" (count block next)
    logic r_reject_out;

    scmd5_pkg::t_rnd_ctl rnd_ctl;
    logic        rnd_init;
    logic [3:0]  msg_idx;
    logic [31:0] msg_word;
    logic        rnd_busy, rnd_done;
    logic [31:0] hash [4];

    logic        acc;
    logic        past_now;
    logic [5:0]  off;
    logic [5:0]  rem;
    logic [31:0] bits;
    logic [31:0] pay_now;
    logic [7:0]  MAGIC_BYTE;

    assign acc = i_valid && !o_stall;
    assign past_now = r_past_hdr || (r_total >= 32'(scmd5_pkg::HDR_LEN));
    assign off = 6'(r_total - 32'(scmd5_pkg::HDR_LEN));
    assign rem = r_pay[5:0];
    assign bits = {r_pay[28:0], 3'b000};
    assign pay_now = r_total + 32'd1 - 32'(scmd5_pkg::HDR_LEN);
    assign MAGIC_BYTE = scmd5_pkg::MAGIC[8*r_total[1:0] +: 8];

    scmd5_round u_round (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (rnd_ctl),
        .i_init     (rnd_init),
        .i_msg_word (msg_word),
        .o_msg_idx  (msg_idx),
        .o_busy     (rnd_busy),
        .o_done     (rnd_done),
        .o_hash     (hash)
    );

    // one message byte as the current block sees it
    function automatic logic [7:0] blk_byte(input logic [5:0] p,
                                            input logic [7:0] st,
                                            input logic [7:0] st4,
                                            input scmd5_pkg::t_state s,
                                            input logic [5:0] rm,
                                            input logic [31:0] bt,
                                            input logic lng);
        logic [31:0] w15;
        logic [7:0]  v;
        w15 = {2'b00, bt[31:2]} | 32'd1;
        v = 8'h00;
        if (s == scmd5_pkg::ST_HASH) begin
            v = st;
        end else if (s == scmd5_pkg::ST_FIN1) begin
            if (p < rm) v = st;
            else if (p == rm) v = 8'h80;
        end else begin
            if (p < 6'd4) v = bt[8*p[1:0] +: 8];
            else if (!lng && (p - 6'd4) < rm) v = st4;
            else if (!lng && (p - 6'd4) == rm) v = 8'h80;
            if (p >= 6'd60) v = w15[8*p[1:0] +: 8];
        end
        return v;
    endfunction

    // message word assembly for the round unit; the count block sees the
    // tail four bytes on, which is exactly the previous stored word
    always_comb begin
        logic [5:0]  base;
        logic [31:0] w_cur;
        logic [31:0] w_prev;
        base = {msg_idx, 2'b00};
        w_cur = r_store[msg_idx];
        w_prev = r_store[msg_idx - 4'd1];
        for (int k = 0; k < 4; k++) begin
            msg_word[8*k +: 8] = blk_byte(6'(base + 6'(k)),
                                          w_cur[8*k +: 8],
                                          w_prev[8*k +: 8],
                                          r_state, rem, bits, r_long);
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        rnd_ctl.start = 1'b0;
        rnd_init = 1'b0;
        unique case (r_state)
            scmd5_pkg::ST_TAKE: begin
                if (acc) begin
                    if (i_last_byte) begin
                        if (!r_magic_ok || !past_now
                            || (r_total < 4 && i_data_byte != MAGIC_BYTE)) begin
                            n_state = scmd5_pkg::ST_OUT;
                        end else if (past_now && off == 6'd63) begin
                            n_state = scmd5_pkg::ST_HASH;
                            rnd_ctl.start = 1'b1;
                        end else if (pay_now[5:0] >= 6'(scmd5_pkg::TAIL_LIMIT)) begin
                            n_state = scmd5_pkg::ST_FIN1;
                            rnd_ctl.start = 1'b1;
                        end else begin
                            n_state = scmd5_pkg::ST_FIN2;
                            rnd_ctl.start = 1'b1;
                        end
                    end else if (past_now && off == 6'd63) begin
                        n_state = scmd5_pkg::ST_HASH;
                        rnd_ctl.start = 1'b1;
                    end
                end
            end
            scmd5_pkg::ST_HASH: begin
                if (rnd_done) begin
                    if (r_reject) begin
                        n_state = scmd5_pkg::ST_FIN2;
                        rnd_ctl.start = 1'b1;
                    end else begin
                        n_state = scmd5_pkg::ST_TAKE;
                    end
                end
            end
            scmd5_pkg::ST_FIN1: begin
                if (rnd_done) begin
                    n_state = scmd5_pkg::ST_FIN2;
                    rnd_ctl.start = 1'b1;
                end
            end
            scmd5_pkg::ST_FIN2: begin
                if (rnd_done) n_state = scmd5_pkg::ST_OUT;
            end
            scmd5_pkg::ST_OUT: begin
                if (!i_stall && (r_reject_out || r_widx == 2'd3)) begin
                    n_state = scmd5_pkg::ST_TAKE;
                    rnd_init = 1'b1;
                end
            end
            default: n_state = scmd5_pkg::ST_TAKE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= scmd5_pkg::ST_TAKE;
            r_total      <= '0;
            r_magic_ok   <= 1'b1;
            r_past_hdr   <= 1'b0;
            r_reject     <= 1'b0;
            r_reject_out <= 1'b0;
            r_long       <= 1'b0;
            r_widx       <= '0;
            r_pay        <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == scmd5_pkg::ST_TAKE && acc) begin
                r_total <= r_total + 32'd1;
                if (r_total < 4 && i_data_byte != MAGIC_BYTE) r_magic_ok <= 1'b0;
                if (past_now) r_past_hdr <= 1'b1;
                r_pay <= pay_now;
                if (i_last_byte) begin
                    r_reject     <= past_now && off == 6'd63;
                    r_reject_out <= !r_magic_ok || !past_now
                                    || (r_total < 4 && i_data_byte != MAGIC_BYTE);
                    r_long       <= pay_now[5:0] >= 6'(scmd5_pkg::TAIL_LIMIT);
                end else begin
                    r_reject <= 1'b0;
                end
            end
            if (r_state == scmd5_pkg::ST_OUT && !i_stall) begin
                r_widx <= r_widx + 2'd1;
                if (n_state == scmd5_pkg::ST_TAKE) begin
                    r_total      <= '0;
                    r_magic_ok   <= 1'b1;
                    r_past_hdr   <= 1'b0;
                    r_reject     <= 1'b0;
                    r_reject_out <= 1'b0;
                    r_long       <= 1'b0;
                    r_widx       <= '0;
                end
            end
        end
    end

    // payload byte store
    always_ff @(posedge i_clk) begin
        if (r_state == scmd5_pkg::ST_TAKE && acc && past_now) begin
            r_store[off[5:2]][8*off[1:0] +: 8] <= i_data_byte;
        end
    end

    assign o_stall         = r_state != scmd5_pkg::ST_TAKE;
    assign o_valid         = r_state == scmd5_pkg::ST_OUT;
    assign o_status        = r_reject_out;
    assign o_word_index    = r_reject_out ? 2'd0 : r_widx;
    assign o_checksum_word = r_reject_out ? 32'd0 : hash[r_widx];
    assign o_last_of_run   = r_reject_out || r_widx == 2'd3;

`ifndef ASSERT_OFF
    a_out_idle_rnd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !rnd_busy) else $error("result while rounds run");
    a_fin_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scmd5_pkg::ST_FIN2 && !rnd_done) |-> rnd_busy)
        else $error("final block idle");
    a_reject_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> o_last_of_run) else $error("reject not last");
`endif

endmodule

// ----- tb/sv/tb_shader_container_md5_checksum.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_shader_container_md5_checksum : checksum block self-checking bench
// Feeds whole containers byte by byte: good ones of many payload lengths,
// bad magic and short ones. A local model of the modified MD5 predicts the
// result words, which the monitor checks in order against the outputs.
// ----------------------------------------------------------------------------
module tb_shader_container_md5_checksum;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_word;

    typedef struct packed {
        logic        status;
        logic [1:0]  index;
        logic [31:0] word;
        logic        last;
    } t_sum_word;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_data = '0;
    logic        in_last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        out_status;
    logic [1:0]  out_index;
    logic [31:0] out_word;
    logic        out_last;

    t_byte_word  pending_bytes[$];
    t_sum_word   expected_sums[$];
    int          fail_count = 0;
    int          byte_count = 0;
    int          sum_count = 0;
    int          run_count = 0;
    bit          stim_done = 1'b0;

    // predictor state
    logic [31:0] hw [4];
    logic [7:0]  blk [64];
    logic [31:0] total;
    bit          magic_ok;
    bit          in_payload;

    shader_container_md5_checksum dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_data_byte    (in_data),
        .i_last_byte    (in_last),
        .o_valid        (out_valid),
        .i_stall        (out_stall),
        .o_status       (out_status),
        .o_word_index   (out_index),
        .o_checksum_word(out_word),
        .o_last_of_run  (out_last)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        return (n == 0) ? v : ((v << n) | (v >> (32 - n)));
    endfunction

    function automatic logic [31:0] sine_const(input int i);
        logic [31:0] t [64];
        t = '{
            32'hd76aa478,32'he8c7b756,32'h242070db,32'hc1bdceee,
            32'hf57c0faf,32'h4787c62a,32'ha8304613,32'hfd469501,
            32'h698098d8,32'h8b44f7af,32'hffff5bb1,32'h895cd7be,
            32'h6b901122,32'hfd987193,32'ha679438e,32'h49b40821,
            32'hf61e2562,32'hc040b340,32'h265e5a51,32'he9b6c7aa,
            32'hd62f105d,32'h02441453,32'hd8a1e681,32'he7d3fbc8,
            32'h21e1cde6,32'hc33707d6,32'hf4d50d87,32'h455a14ed,
            32'ha9e3e905,32'hfcefa3f8,32'h676f02d9,32'h8d2a4c8a,
            32'hfffa3942,32'h8771f681,32'h6d9d6122,32'hfde5380c,
            32'ha4beea44,32'h4bdecfa9,32'hf6bb4b60,32'hbebfbc70,
            32'h289b7ec6,32'heaa127fa,32'hd4ef3085,32'h04881d05,
            32'hd9d4d039,32'he6db99e5,32'h1fa27cf8,32'hc4ac5665,
            32'hf4292244,32'h432aff97,32'hab9423a7,32'hfc93a039,
            32'h655b59c3,32'h8f0ccc92,32'hffeff47d,32'h85845dd1,
            32'h6fa87e4f,32'hfe2ce6e0,32'ha3014314,32'h4e0811a1,
            32'hf7537e82,32'hbd3af235,32'h2ad7d2bb,32'heb86d391};
        return t[i];
    endfunction

    // one block of standard MD5 rounds into hw
    task automatic compress(input logic [7:0] b [64]);
        logic [31:0] w [16];
        logic [31:0] a, bb, c, d, f, tmp;
        int g;
        int sh [16];
        sh = '{7,12,17,22, 5,9,14,20, 4,11,16,23, 6,10,15,21};
        for (int k = 0; k < 16; k++)
            w[k] = {b[4*k+3], b[4*k+2], b[4*k+1], b[4*k]};
        a = hw[0]; bb = hw[1]; c = hw[2]; d = hw[3];
        for (int i = 0; i < 64; i++) begin
            if (i < 16) begin
                f = (bb & c) | (~bb & d); g = i;
            end else if (i < 32) begin
                f = (d & bb) | (~d & c); g = (5*i + 1) % 16;
            end else if (i < 48) begin
                f = bb ^ c ^ d; g = (3*i + 5) % 16;
            end else begin
                f = c ^ (bb | ~d); g = (7*i) % 16;
            end
            tmp = d; d = c; c = bb;
            bb = bb + rotl(a + f + sine_const(i) + w[g], sh[{i[5:4], i[1:0]}]);
            a = tmp;
        end
        hw[0] += a; hw[1] += bb; hw[2] += c; hw[3] += d;
    endtask

    task automatic clear_model();
        hw = '{scmd5_pkg::H0, scmd5_pkg::H1, scmd5_pkg::H2, scmd5_pkg::H3};
        total = 0; magic_ok = 1'b1; in_payload = 1'b0;
    endtask

    // step the checksum model by one accepted byte
    task automatic predict_byte(input t_byte_word bw);
        logic [7:0]  fin [64];
        logic [31:0] pay, bits;
        int rem;
        if (!in_payload) begin
            if (total < 4 && bw.data != scmd5_pkg::MAGIC[8*total +: 8]) magic_ok = 1'b0;
            if (total >= scmd5_pkg::HDR_LEN) in_payload = 1'b1;
        end
        if (in_payload) begin
            blk[6'(total - scmd5_pkg::HDR_LEN)] = bw.data;
            if (6'(total - scmd5_pkg::HDR_LEN) == 6'd63) compress(blk);
        end
        total += 1;
        if (!bw.last) return;
        run_count++;
        if (!magic_ok || !in_payload) begin
            expected_sums.push_back('{1'b1, 2'd0, 32'd0, 1'b1});
        end else begin
            pay = total - scmd5_pkg::HDR_LEN;
            rem = pay & 63;
            bits = pay << 3;
            foreach (fin[k]) fin[k] = 8'h00;
            if (rem >= scmd5_pkg::TAIL_LIMIT) begin
                for (int k = 0; k < rem; k++) fin[k] = blk[k];
                fin[rem] = 8'h80;
                compress(fin);
                foreach (fin[k]) fin[k] = 8'h00;
                {fin[3], fin[2], fin[1], fin[0]} = bits;
            end else begin
                {fin[3], fin[2], fin[1], fin[0]} = bits;
                for (int k = 0; k < rem; k++) fin[4 + k] = blk[k];
                fin[4 + rem] = 8'h80;
            end
            {fin[63], fin[62], fin[61], fin[60]} = (bits >> 2) | 32'd1;
            compress(fin);
            for (int k = 0; k < 4; k++)
                expected_sums.push_back('{1'b0, k[1:0], hw[k], k == 3});
        end
        clear_model();
    endtask

    // queue one container; kind 0 good, 1 bad magic
    task automatic add_container(input int len, input bit bad_magic, input int fill);
        logic [7:0] v;
        int bad_pos;
        bad_pos = $urandom_range(0, 3);
        for (int k = 0; k < len; k++) begin
            case (fill)
                0: v = 8'($urandom);
                1: v = 8'h00;
                default: v = 8'hff;
            endcase
            if (k < 4) begin
                v = scmd5_pkg::MAGIC[8*k +: 8];
                if (bad_magic && k == bad_pos) v = v ^ (8'h01 << $urandom_range(0, 7));
            end
            pending_bytes.push_back('{v, k == len - 1});
        end
    endtask

    // driver: bursts and gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                predict_byte('{in_data, in_last});
                byte_count++;
            end
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    {in_data, in_last} <= pending_bytes.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall pattern
    int stall_phase = 0;
    always @(posedge clk) begin
        t_sum_word got, want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                got = '{out_status, out_index, out_word, out_last};
                sum_count++;
                if (expected_sums.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h", $time, got);
                    fail_count++;
                end else begin
                    want = expected_sums.pop_front();
                    if (got.status != want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        fail_count++;
                    end
                    if (got.index != want.index) begin
                        $display("%0t: word_index expected %0d actual %0d",
                                 $time, want.index, got.index);
                        fail_count++;
                    end
                    if (got.word != want.word) begin
                        $display("%0t: checksum_word expected %h actual %h",
                                 $time, want.word, got.word);
                        fail_count++;
                    end
                    if (got.last != want.last) begin
                        $display("%0t: last_of_run expected %0d actual %0d",
                                 $time, want.last, got.last);
                        fail_count++;
                    end
                end
            end
            stall_phase <= (stall_phase + 1) % 97;
            out_stall <= (stall_phase < 30) ? 1'b0 : ($urandom_range(0, 2) == 0);
        end
    end

    // stimulus and end of run
    initial begin
        int len;
        clear_model();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        // directed: short, boundary and padding split cases
        add_container(20, 0, 0);
        add_container(21, 0, 1);
        add_container(1, 0, 0);
        add_container(4, 1, 0);
        add_container(30, 1, 2);
        add_container(20 + 55, 0, 2);
        add_container(20 + 56, 0, 0);
        add_container(20 + 63, 0, 1);
        add_container(20 + 64, 0, 2);
        add_container(20 + 65, 0, 0);
        // random containers, mostly good, until at least 480 bytes; trimmed to keep the total at most 500
        while (pending_bytes.size() < 480) begin
            case ($urandom_range(0, 9))
                0: len = $urandom_range(1, 20);
                1: len = $urandom_range(21, 60);
                default: len = 20 + $urandom_range(0, 140);
            endcase
            if (len > 500 - pending_bytes.size()) len = 500 - pending_bytes.size();
            add_container(len, $urandom_range(0, 7) == 0, $urandom_range(0, 9) == 0);
        end
        wait (pending_bytes.size() == 0 && !in_valid);
        wait (expected_sums.size() == 0);
        repeat (300) @(posedge clk);
        $display("Checked %0d containers, %0d bytes in, %0d result words out.",
                 run_count, byte_count, sum_count);
        if (fail_count == 0 && expected_sums.size() == 0) begin
            $display("PASS shader_container_md5_checksum");
        end else begin
            $display("FAIL shader_container_md5_checksum");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAIL shader_container_md5_checksum");
        $finish;
    end

endmodule
